/* hw/rtl/vwlw_pkg.sv */
// ----------------------------------------------------------------------------
// vwlw_pkg: shared definitions for the vessel wind load wrench unit
// Widths, constants, register codes and data types used by the unit's files.
// ----------------------------------------------------------------------------
package vwlw_pkg;

  localparam int unsigned CORDIC_STAGES_DEF = 16;

  // Vectoring datapath width, rotation datapath width, rotation matrix entry width.
  localparam int unsigned XW = 35;
  localparam int unsigned CW = 33;
  localparam int unsigned RW = 34;

  // Inverse CORDIC gain in Q.30.
  localparam logic signed [CW-1:0] INV_GAIN_Q30 = 33'sd652032874;

  // Symmetric saturation limit for intermediate products, 2^60 - 1.
  localparam logic [60:0] SAT_LIM = {1'b0, {60{1'b1}}};

  // Air density reset value, 1.12 in Q4.12.
  localparam logic [15:0] RHO_RESET = 16'd4588;

  // Configuration register indexes.
  localparam logic [2:0] REG_FRONTAL_AREA   = 3'd0;
  localparam logic [2:0] REG_LATERAL_AREA   = 3'd1;
  localparam logic [2:0] REG_OVERALL_LENGTH = 3'd2;
  localparam logic [2:0] REG_AIR_DENSITY    = 3'd3;
  localparam logic [2:0] REG_SURGE_COEFF    = 3'd4;
  localparam logic [2:0] REG_SWAY_COEFF     = 3'd5;
  localparam logic [2:0] REG_YAW_COEFF      = 3'd6;

  // State handed from one CORDIC cell to the next.
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [CW-1:0] c;
    logic signed [CW-1:0] s;
  } cord_t;

  // One result item.
  typedef struct packed {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
    logic signed [47:0] tx;
    logic signed [47:0] ty;
    logic signed [47:0] tz;
  } wrench_t;

  // Rounds a Q.30 trig value to Q.16, half away from zero.
  function automatic logic signed [17:0] rnd_q14(input logic signed [CW-1:0] v);
    logic [CW-1:0] mag;
    logic [CW-1:0] r;
    mag = v[CW-1] ? CW'(-v) : CW'(v);
    r   = (mag + CW'(1 << 13)) >> 14;
    return v[CW-1] ? -$signed(r[17:0]) : $signed(r[17:0]);
  endfunction

endpackage

/* hw/rtl/vessel_wind_load_wrench_unit.sv */
// ----------------------------------------------------------------------------
// vessel_wind_load_wrench_unit: wind force and torque on a surface vessel
// Each item carries a body-to-world quaternion (Q1.14) and world-frame vessel
// and wind velocities (Q8.8). The unit rotates the relative velocity into the
// body frame, finds the angle of attack with a chain of CORDIC cells, forms
// surge force, sway force and yaw moment from the programmed coefficients,
// areas, length and air density, and rotates force and torque back to the
// world frame with saturation. The datapath is a fully pipelined row of
// stages, so one item is accepted every cycle while in_stall_o is low. The
// CORDIC chain adds one register per cell, and the three-stage multipliers
// in the quaternion, force and back-rotation paths supply most of the rest.
// A two-entry output buffer lets the pipeline keep taking
// items while a finished result waits; in_stall_o rises only once both entries
// are full. When both body-frame velocity components round to zero, every
// output field is zero. Configuration registers are written through the APB
// port and must only be changed while no item is in flight.
// ----------------------------------------------------------------------------
module vessel_wind_load_wrench_unit #(
  parameter int unsigned CORDIC_STAGES = vwlw_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] vessel_vel_x_i,
  input  logic signed [15:0] vessel_vel_y_i,
  input  logic signed [15:0] vessel_vel_z_i,
  input  logic signed [15:0] wind_vel_x_i,
  input  logic signed [15:0] wind_vel_y_i,
  input  logic signed [15:0] wind_vel_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] force_x_o,
  output logic signed [31:0] force_y_o,
  output logic signed [31:0] force_z_o,
  output logic signed [47:0] torque_x_o,
  output logic signed [47:0] torque_y_o,
  output logic signed [47:0] torque_z_o
);
  import vwlw_pkg::*;

  localparam int unsigned N = CORDIC_STAGES;

  // Pipeline timing: the stage index at which each value is registered.
  localparam int unsigned T_CS     = N + 9;
  localparam int unsigned T_T      = N + 15;
  localparam int unsigned T_F      = N + 24;
  localparam int unsigned T_O      = N + 28;
  localparam int unsigned DLY_P    = T_T - 12;
  localparam int unsigned DLY_R    = T_F - 3;
  localparam int unsigned DLY_Z    = T_F + 3 - 7;

  localparam logic signed [62:0] F_MAX = 63'sd2147483647;
  localparam logic signed [62:0] F_MIN = -63'sd2147483648;
  localparam logic signed [61:0] M_MAX = 62'sd140737488355327;
  localparam logic signed [61:0] M_MIN = -62'sd140737488355328;

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic [23:0] frontal_q;
  logic [23:0] lateral_q;
  logic [23:0] length_q;
  logic [15:0] rho_q;
  logic [15:0] surge_q;
  logic [15:0] sway_q;
  logic [15:0] yaw_q;
  logic        cfg_wr;

  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frontal_q <= '0;
      lateral_q <= '0;
      length_q  <= '0;
      rho_q     <= RHO_RESET;
      surge_q   <= '0;
      sway_q    <= '0;
      yaw_q     <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_FRONTAL_AREA:   frontal_q <= pwdata[23:0];
        REG_LATERAL_AREA:   lateral_q <= pwdata[23:0];
        REG_OVERALL_LENGTH: length_q  <= pwdata[23:0];
        REG_AIR_DENSITY:    rho_q     <= pwdata[15:0];
        REG_SURGE_COEFF:    surge_q   <= pwdata[15:0];
        REG_SWAY_COEFF:     sway_q    <= pwdata[15:0];
        REG_YAW_COEFF:      yaw_q     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_FRONTAL_AREA:   prdata = {8'd0, frontal_q};
      REG_LATERAL_AREA:   prdata = {8'd0, lateral_q};
      REG_OVERALL_LENGTH: prdata = {8'd0, length_q};
      REG_AIR_DENSITY:    prdata = {16'd0, rho_q};
      REG_SURGE_COEFF:    prdata = {16'd0, surge_q};
      REG_SWAY_COEFF:     prdata = {16'd0, sway_q};
      REG_YAW_COEFF:      prdata = {16'd0, yaw_q};
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Flow control. The whole pipeline moves together; it only halts when both
  // the output register and the skid entry hold results.
  // ---------------------------------------------------------------------------
  logic [T_O:1] vld_q;
  logic         adv;
  logic         out_v_q;
  logic         skid_v_q;
  logic         take;
  logic         inc;
  wrench_t      fin_q;
  wrench_t      out_q;
  wrench_t      skid_q;

  assign adv        = ~skid_v_q;
  assign in_stall_o = skid_v_q;
  assign take       = out_v_q & ~out_stall_i;
  assign inc        = adv & vld_q[T_O];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[T_O-1:1], in_valid_i};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input capture and relative velocity.
  // ---------------------------------------------------------------------------
  logic signed [15:0] qw_q, qx_q, qy_q, qz_q;
  logic signed [16:0] r_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      qw_q   <= quat_w_i;
      qx_q   <= quat_x_i;
      qy_q   <= quat_y_i;
      qz_q   <= quat_z_i;
      r_q[0] <= {vessel_vel_x_i[15], vessel_vel_x_i} - {wind_vel_x_i[15], wind_vel_x_i};
      r_q[1] <= {vessel_vel_y_i[15], vessel_vel_y_i} - {wind_vel_y_i[15], wind_vel_y_i};
      r_q[2] <= {vessel_vel_z_i[15], vessel_vel_z_i} - {wind_vel_z_i[15], wind_vel_z_i};
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 2 and 3: quaternion products, then the homogeneous rotation matrix.
  // ---------------------------------------------------------------------------
  logic signed [31:0] pww_q, pxx_q, pyy_q, pzz_q, pxy_q, pwz_q, pxz_q, pwy_q, pyz_q, pwx_q;
  logic signed [RW-1:0] rm_q [3][3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pww_q <= qw_q * qw_q;
      pxx_q <= qx_q * qx_q;
      pyy_q <= qy_q * qy_q;
      pzz_q <= qz_q * qz_q;
      pxy_q <= qx_q * qy_q;
      pwz_q <= qw_q * qz_q;
      pxz_q <= qx_q * qz_q;
      pwy_q <= qw_q * qy_q;
      pyz_q <= qy_q * qz_q;
      pwx_q <= qw_q * qx_q;

      rm_q[0][0] <= RW'(pww_q) + RW'(pxx_q) - RW'(pyy_q) - RW'(pzz_q);
      rm_q[1][1] <= RW'(pww_q) - RW'(pxx_q) + RW'(pyy_q) - RW'(pzz_q);
      rm_q[2][2] <= RW'(pww_q) - RW'(pxx_q) - RW'(pyy_q) + RW'(pzz_q);
      rm_q[0][1] <= (RW'(pxy_q) - RW'(pwz_q)) <<< 1;
      rm_q[1][0] <= (RW'(pxy_q) + RW'(pwz_q)) <<< 1;
      rm_q[0][2] <= (RW'(pxz_q) + RW'(pwy_q)) <<< 1;
      rm_q[2][0] <= (RW'(pxz_q) - RW'(pwy_q)) <<< 1;
      rm_q[1][2] <= (RW'(pyz_q) - RW'(pwx_q)) <<< 1;
      rm_q[2][1] <= (RW'(pyz_q) + RW'(pwx_q)) <<< 1;
    end
  end

  // Relative velocity waits in a shift line for the matrix.
  logic [50:0] r_dly;
  logic signed [16:0] rd [3];

  vwlw_delay #(.W(51), .D(2)) u_dly_r (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   ({r_q[2], r_q[1], r_q[0]}),
    .q_o   (r_dly)
  );

  assign rd[0] = r_dly[16:0];
  assign rd[1] = r_dly[33:17];
  assign rd[2] = r_dly[50:34];

  // ---------------------------------------------------------------------------
  // Stages 4 to 7: body-frame horizontal velocity (transpose times r).
  // ---------------------------------------------------------------------------
  logic signed [23:0] br [3][2];

  for (genvar i = 0; i < 3; i++) begin : g_body
    for (genvar j = 0; j < 2; j++) begin : g_col
      vwlw_mul #(.AW(RW), .BW(17), .SH(28), .OW(24)) u_mul (
        .clk_i (clk_i),
        .en_i  (adv),
        .a_i   (rm_q[i][j]),
        .b_i   (rd[i]),
        .p_o   (br[i][j])
      );
    end
  end

  logic signed [25:0] bx_sum, by_sum;
  logic signed [25:0] bx_q, by_q;
  logic               zero_q;

  assign bx_sum = 26'(br[0][0]) + 26'(br[1][0]) + 26'(br[2][0]);
  assign by_sum = 26'(br[0][1]) + 26'(br[1][1]) + 26'(br[2][1]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      bx_q   <= bx_sum;
      by_q   <= by_sum;
      zero_q <= (bx_sum == '0) && (by_sum == '0);
    end
  end

  // ---------------------------------------------------------------------------
  // Squared speed and dynamic pressure.
  // ---------------------------------------------------------------------------
  logic signed [51:0] sqx_q, sqy_q;
  logic signed [46:0] spd2_q;
  logic signed [41:0] pres;
  logic signed [41:0] pres_d;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqx_q  <= bx_q * bx_q;
      sqy_q  <= by_q * by_q;
      spd2_q <= 47'(sqx_q) + 47'(sqy_q);
    end
  end

  vwlw_mul #(.AW(47), .BW(17), .SH(21), .OW(42)) u_mul_p (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (spd2_q),
    .b_i   ({1'b0, rho_q}),
    .p_o   (pres)
  );

  vwlw_delay #(.W(42), .D(DLY_P)) u_dly_p (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (pres),
    .q_o   (pres_d)
  );

  // ---------------------------------------------------------------------------
  // CORDIC: a pre-rotation by half a turn for negative bx, then a row of
  // cells that each run one vectoring and one rotation step in lockstep.
  // ---------------------------------------------------------------------------
  logic signed [XW-1:0] cx0, cy0;
  logic                 flip_q;
  logic                 flip_d;
  cord_t                chain [N+1];

  assign cx0 = XW'(bx_q) <<< 8;
  assign cy0 = XW'(by_q) <<< 8;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      flip_q     <= bx_q[25];
      chain[0].x <= bx_q[25] ? -cx0 : cx0;
      chain[0].y <= bx_q[25] ? -cy0 : cy0;
      chain[0].c <= INV_GAIN_Q30;
      chain[0].s <= '0;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_cell
    vwlw_cordic_cell #(.SHIFT(k)) u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .d_i   (chain[k]),
      .q_o   (chain[k+1])
    );
  end

  vwlw_delay #(.W(1), .D(N)) u_dly_flip (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (flip_q),
    .q_o   (flip_d)
  );

  logic signed [17:0] cs_q, sn_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cs_q <= rnd_q14(flip_d ? -chain[N].c : chain[N].c);
      sn_q <= rnd_q14(flip_d ? -chain[N].s : chain[N].s);
    end
  end

  // ---------------------------------------------------------------------------
  // Coefficient terms: -surge*cos, sway*(-sin), yaw*(-2 sin cos).
  // ---------------------------------------------------------------------------
  logic signed [16:0] nsurge;
  logic signed [18:0] nsn;
  logic signed [19:0] m2sn;
  logic signed [25:0] tx_t, ty_t, tn_t;
  logic signed [21:0] dbl_t;
  logic [51:0]        txy_d;

  assign nsurge = -{surge_q[15], surge_q};
  assign nsn    = -{sn_q[17], sn_q};
  assign m2sn   = -({{2{sn_q[17]}}, sn_q} <<< 1);

  vwlw_mul #(.AW(18), .BW(17), .SH(12), .OW(26)) u_mul_tx (
    .clk_i (clk_i), .en_i (adv), .a_i (cs_q), .b_i (nsurge), .p_o (tx_t)
  );

  vwlw_mul #(.AW(19), .BW(16), .SH(12), .OW(26)) u_mul_ty (
    .clk_i (clk_i), .en_i (adv), .a_i (nsn), .b_i (sway_q), .p_o (ty_t)
  );

  vwlw_mul #(.AW(20), .BW(18), .SH(16), .OW(22)) u_mul_dbl (
    .clk_i (clk_i), .en_i (adv), .a_i (m2sn), .b_i (cs_q), .p_o (dbl_t)
  );

  vwlw_mul #(.AW(22), .BW(16), .SH(12), .OW(26)) u_mul_tn (
    .clk_i (clk_i), .en_i (adv), .a_i (dbl_t), .b_i (yaw_q), .p_o (tn_t)
  );

  vwlw_delay #(.W(52), .D(3)) u_dly_txy (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   ({ty_t, tx_t}),
    .q_o   (txy_d)
  );

  // ---------------------------------------------------------------------------
  // Body-frame force and moment.
  // ---------------------------------------------------------------------------
  logic signed [49:0] fx1, fy1, tz1;
  logic signed [61:0] fxb, fyb, tz2, tzb;
  logic [123:0]       fxy_d;
  logic signed [61:0] fxb_d, fyb_d;

  vwlw_mul #(.AW(42), .BW(26), .SH(16), .OW(50)) u_mul_fx1 (
    .clk_i (clk_i), .en_i (adv), .a_i (pres_d), .b_i (txy_d[25:0]), .p_o (fx1)
  );

  vwlw_mul #(.AW(42), .BW(26), .SH(16), .OW(50)) u_mul_fy1 (
    .clk_i (clk_i), .en_i (adv), .a_i (pres_d), .b_i (txy_d[51:26]), .p_o (fy1)
  );

  vwlw_mul #(.AW(42), .BW(26), .SH(16), .OW(50)) u_mul_tz1 (
    .clk_i (clk_i), .en_i (adv), .a_i (pres_d), .b_i (tn_t), .p_o (tz1)
  );

  vwlw_mul #(.AW(50), .BW(25), .SH(8), .OW(62)) u_mul_fx (
    .clk_i (clk_i), .en_i (adv), .a_i (fx1), .b_i ({1'b0, frontal_q}), .p_o (fxb)
  );

  vwlw_mul #(.AW(50), .BW(25), .SH(8), .OW(62)) u_mul_fy (
    .clk_i (clk_i), .en_i (adv), .a_i (fy1), .b_i ({1'b0, lateral_q}), .p_o (fyb)
  );

  vwlw_mul #(.AW(50), .BW(25), .SH(8), .OW(62)) u_mul_tz2 (
    .clk_i (clk_i), .en_i (adv), .a_i (tz1), .b_i ({1'b0, lateral_q}), .p_o (tz2)
  );

  vwlw_mul #(.AW(62), .BW(25), .SH(8), .OW(62)) u_mul_tz (
    .clk_i (clk_i), .en_i (adv), .a_i (tz2), .b_i ({1'b0, length_q}), .p_o (tzb)
  );

  vwlw_delay #(.W(124), .D(3)) u_dly_fxy (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   ({fyb, fxb}),
    .q_o   (fxy_d)
  );

  assign fxb_d = fxy_d[61:0];
  assign fyb_d = fxy_d[123:62];

  // ---------------------------------------------------------------------------
  // Back-rotation to the world frame. The matrix rides along in a shift line.
  // ---------------------------------------------------------------------------
  logic [9*RW-1:0]      rm_flat;
  logic [9*RW-1:0]      rm_flat_d;
  logic signed [RW-1:0] rmd [3][3];

  for (genvar i = 0; i < 3; i++) begin : g_rflat
    for (genvar j = 0; j < 3; j++) begin : g_rcol
      assign rm_flat[(3*i+j)*RW +: RW] = rm_q[i][j];
      assign rmd[i][j] = rm_flat_d[(3*i+j)*RW +: RW];
    end
  end

  vwlw_delay #(.W(9*RW), .D(DLY_R)) u_dly_rm (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (rm_flat),
    .q_o   (rm_flat_d)
  );

  logic signed [61:0] wf0 [3];
  logic signed [61:0] wf1 [3];
  logic signed [61:0] wm  [3];

  for (genvar i = 0; i < 3; i++) begin : g_world
    vwlw_mul #(.AW(62), .BW(RW), .SH(28), .OW(62)) u_mul_f0 (
      .clk_i (clk_i), .en_i (adv), .a_i (fxb_d), .b_i (rmd[i][0]), .p_o (wf0[i])
    );
    vwlw_mul #(.AW(62), .BW(RW), .SH(28), .OW(62)) u_mul_f1 (
      .clk_i (clk_i), .en_i (adv), .a_i (fyb_d), .b_i (rmd[i][1]), .p_o (wf1[i])
    );
    vwlw_mul #(.AW(62), .BW(RW), .SH(28), .OW(62)) u_mul_m (
      .clk_i (clk_i), .en_i (adv), .a_i (tzb), .b_i (rmd[i][2]), .p_o (wm[i])
    );
  end

  logic zero_d;

  vwlw_delay #(.W(1), .D(DLY_Z)) u_dly_zero (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (zero_q),
    .q_o   (zero_d)
  );

  // Final stage: sum, clamp to the output field ranges, force zero at rest.
  logic signed [62:0] fsum [3];
  logic signed [31:0] fcl  [3];
  logic signed [47:0] mcl  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fsum[i] = 63'(wf0[i]) + 63'(wf1[i]);
      if (fsum[i] > F_MAX) begin
        fcl[i] = F_MAX[31:0];
      end else if (fsum[i] < F_MIN) begin
        fcl[i] = F_MIN[31:0];
      end else begin
        fcl[i] = fsum[i][31:0];
      end
      if (wm[i] > M_MAX) begin
        mcl[i] = M_MAX[47:0];
      end else if (wm[i] < M_MIN) begin
        mcl[i] = M_MIN[47:0];
      end else begin
        mcl[i] = wm[i][47:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fin_q.fx <= zero_d ? '0 : fcl[0];
      fin_q.fy <= zero_d ? '0 : fcl[1];
      fin_q.fz <= zero_d ? '0 : fcl[2];
      fin_q.tx <= zero_d ? '0 : mcl[0];
      fin_q.ty <= zero_d ? '0 : mcl[1];
      fin_q.tz <= zero_d ? '0 : mcl[2];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register with one skid entry.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (take) begin
        skid_v_q <= 1'b0;
      end
    end else if (inc) begin
      if (out_v_q && !take) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (take) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (inc) begin
      if (out_v_q && !take) begin
        skid_q <= fin_q;
      end else begin
        out_q <= fin_q;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign force_x_o   = out_q.fx;
  assign force_y_o   = out_q.fy;
  assign force_z_o   = out_q.fz;
  assign torque_x_o  = out_q.tx;
  assign torque_y_o  = out_q.ty;
  assign torque_z_o  = out_q.tz;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // The skid entry only fills behind a result already held in the output register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry valid without an output result");

  // While the pipeline is halted, no item moves between stages.
  a_halt_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline valid bits moved while halted");

  // A taken result with a full skid entry is followed by the skid result.
  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && !out_stall_i) |=> (out_valid_o && !skid_v_q))
    else $error("skid entry did not move to the output");

endmodule

/* hw/rtl/vwlw_mul.sv */
// ----------------------------------------------------------------------------
// vwlw_mul: pipelined rounding and saturating multiplier
// Sign-magnitude product split into two partial products, then a rounding
// shift that rounds half away from zero and saturates at 2^60 - 1.
// The magnitude, partial product and output stages are registered.
// ----------------------------------------------------------------------------
module vwlw_mul #(
  parameter int unsigned AW = 34,
  parameter int unsigned BW = 17,
  parameter int unsigned SH = 28,
  parameter int unsigned OW = 24
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output logic signed [OW-1:0] p_o
);
  import vwlw_pkg::*;

  localparam int unsigned LW  = AW / 2;
  localparam int unsigned HW  = AW - LW;
  localparam int unsigned PW  = AW + BW;
  localparam int unsigned RDW = PW + 1;
  localparam int unsigned CMW = (RDW > 61) ? RDW : 61;

  logic [AW-1:0]      ma_q;
  logic [BW-1:0]      mb_q;
  logic               neg1_q;
  logic               neg2_q;
  logic [LW+BW-1:0]   pl_q;
  logic [HW+BW-1:0]   ph_q;
  logic [PW-1:0]      sum;
  logic [CMW-1:0]     rnd;
  logic [CMW-1:0]     mag;
  logic signed [CMW:0] res;

  always_comb begin
    sum = (PW'(ph_q) << LW) + PW'(pl_q);
    rnd = (CMW'(sum) + (CMW'(1) << (SH - 1))) >> SH;
    mag = (rnd > CMW'(SAT_LIM)) ? CMW'(SAT_LIM) : rnd;
    res = neg2_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q   <= a_i[AW-1] ? AW'(-a_i) : AW'(a_i);
      mb_q   <= b_i[BW-1] ? BW'(-b_i) : BW'(b_i);
      neg1_q <= a_i[AW-1] ^ b_i[BW-1];
      pl_q   <= ma_q[LW-1:0] * mb_q;
      ph_q   <= ma_q[AW-1:LW] * mb_q;
      neg2_q <= neg1_q;
      p_o    <= OW'(res);
    end
  end

endmodule

/* hw/rtl/vwlw_delay.sv */
// ----------------------------------------------------------------------------
// vwlw_delay: enabled shift line
// Carries side data alongside the arithmetic stages through D enabled registers.
// ----------------------------------------------------------------------------
module vwlw_delay #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] line_q [D];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      line_q[0] <= d_i;
      for (int k = 1; k < D; k++) begin
        line_q[k] <= line_q[k-1];
      end
    end
  end

  assign q_o = line_q[D-1];

endmodule

/* hw/rtl/vwlw_cordic_cell.sv */
// ----------------------------------------------------------------------------
// vwlw_cordic_cell: one CORDIC micro-rotation
// The vectoring half picks a direction from the sign of y; the rotation half
// applies that same direction to the cosine and sine pair.
// ----------------------------------------------------------------------------
module vwlw_cordic_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  vwlw_pkg::cord_t d_i,
  output vwlw_pkg::cord_t q_o
);
  import vwlw_pkg::*;

  logic signed [XW-1:0] x;
  logic signed [XW-1:0] y;
  logic signed [CW-1:0] c;
  logic signed [CW-1:0] s;
  logic                 dir;
  cord_t                nxt;

  always_comb begin
    x   = d_i.x;
    y   = d_i.y;
    c   = d_i.c;
    s   = d_i.s;
    dir = ~y[XW-1];
    if (dir) begin
      nxt.x = x + (y >>> SHIFT);
      nxt.y = y - (x >>> SHIFT);
      nxt.c = c - (s >>> SHIFT);
      nxt.s = s + (c >>> SHIFT);
    end else begin
      nxt.x = x - (y >>> SHIFT);
      nxt.y = y + (x >>> SHIFT);
      nxt.c = c + (s >>> SHIFT);
      nxt.s = s - (c >>> SHIFT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_o <= nxt;
    end
  end

endmodule
